### hw/rtl/rrtp_pkg.sv
// Shared types and codes for the round-robin task picker.
// No dependencies; imported by every module of the block.
package rrtp_pkg;

	localparam int NUM_ENTRIES_DEF = 1024;
	localparam int IDX_W           = 10;
	localparam int ST_W            = 3;

	// task status codes
	localparam logic [ST_W-1:0] ST_FREE     = 3'd0;
	localparam logic [ST_W-1:0] ST_DYING    = 3'd1;
	localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd2;
	localparam logic [ST_W-1:0] ST_RUNNING  = 3'd3;

	// word kinds on the task channel
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_YIELD = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] entry_index;
		logic [ST_W-1:0]  new_status;
	} task_word_t;

	typedef struct packed {
		logic             chosen_valid;
		logic [IDX_W-1:0] chosen_index;
		logic             kept_current;
		logic             no_live_tasks;
	} pick_word_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic wr_en;
		logic scan_start;
		logic scan_issue;
		logic scan_eval;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_more;
		logic hit;
		logic scan_end;
		logic out_free;
	} ctl_sts_t;

endpackage

### hw/rtl/rrtp_ctrl.sv
// Controller state machine of the task picker.
// Depends on rrtp_pkg; drives datapath commands from its status.
module rrtp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                task_valid,
	input  logic                task_kind,
	output logic                task_stall,
	input  rrtp_pkg::ctl_sts_t  sts,
	output rrtp_pkg::ctl_cmd_t  cmd
);
	import rrtp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (task_valid && task_kind == KIND_YIELD) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit || sts.scan_end) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		task_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				task_stall     = 1'b0;
				cmd.wr_en      = task_valid && task_kind == KIND_WRITE;
				cmd.scan_start = task_valid && task_kind == KIND_YIELD;
			end
			S_SCAN: begin
				cmd.scan_issue = sts.scan_more && !sts.hit;
				cmd.scan_eval  = 1'b1;
			end
			S_DONE: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hw/rtl/rrtp_datapath.sv
// Datapath of the task picker: status memory, scan pointer, result register.
// Depends on rrtp_pkg; commanded by rrtp_ctrl.
module rrtp_datapath #(
	parameter int NUM_ENTRIES = rrtp_pkg::NUM_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrtp_pkg::task_word_t task_word,
	input  rrtp_pkg::ctl_cmd_t  cmd,
	output rrtp_pkg::ctl_sts_t  sts,
	output logic                pick_valid,
	input  logic                pick_stall,
	output rrtp_pkg::pick_word_t pick_word
);
	import rrtp_pkg::*;

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] a);
		return (a == LAST) ? '0 : a + IW'(1);
	endfunction

	function automatic logic is_live(input logic [ST_W-1:0] s);
		return s == ST_DYING || s == ST_RUNNABLE || s == ST_RUNNING;
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [IW-1:0] a);
		logic [31:0] w;
		w = 32'(a);
		return w[IDX_W-1:0];
	endfunction

	logic [ST_W-1:0] mem [NUM_ENTRIES];
	logic [ST_W-1:0] rd_data_s1;

	logic [IW-1:0] clr_q;
	logic [IW-1:0] addr_q;
	logic [CW-1:0] rem_q;
	logic          vld_s1, last_s1;
	logic [IW-1:0] addr_s1;
	logic          found_q, live_q;
	logic [IW-1:0] pick_q;
	logic [ST_W-1:0] cur_st_q;
	logic [IW-1:0] cur_q;
	logic          cur_valid_q;
	logic          pick_valid_q;
	pick_word_t    pick_word_q;

	logic [31:0]     idx_ext;
	logic            idx_ok;
	logic            wr_go;
	logic [IW-1:0]   wr_addr;
	logic [ST_W-1:0] wr_data;
	logic            eval_go;

	assign idx_ext = 32'(task_word.entry_index);
	assign idx_ok  = idx_ext < 32'(NUM_ENTRIES);
	assign wr_go   = cmd.clr_step | (cmd.wr_en & idx_ok);
	assign wr_addr = cmd.clr_step ? clr_q : idx_ext[IW-1:0];
	assign wr_data = cmd.clr_step ? ST_FREE : task_word.new_status;
	assign eval_go = cmd.scan_eval & vld_s1;

	assign sts.clr_last  = clr_q == LAST;
	assign sts.scan_more = rem_q != '0;
	assign sts.hit       = eval_go && rd_data_s1 == ST_RUNNABLE;
	assign sts.scan_end  = eval_go && last_s1;
	assign sts.out_free  = !pick_valid_q || !pick_stall;

	// status memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_go) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[addr_q];
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && clr_q != LAST) begin
			clr_q <= clr_q + IW'(1);
		end
	end

	// scan pointer and read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= cmd.scan_issue;
			last_s1 <= rem_q == CW'(1);
			if (cmd.scan_start) begin
				addr_q <= cur_valid_q ? nxt(cur_q) : '0;
				rem_q  <= CW'(NUM_ENTRIES);
			end else if (cmd.scan_issue) begin
				addr_q <= nxt(addr_q);
				rem_q  <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
	end

	// scan evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			live_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
			live_q  <= 1'b0;
		end else if (eval_go) begin
			live_q <= live_q | is_live(rd_data_s1);
			if (sts.hit) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.hit) pick_q <= addr_s1;
		// with a current task the final entry scanned is that task
		if (eval_go && last_s1) cur_st_q <= rd_data_s1;
	end

	// current task and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '0;
			cur_valid_q  <= 1'b0;
			pick_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				pick_valid_q <= 1'b1;
				if (found_q) begin
					cur_q       <= pick_q;
					cur_valid_q <= 1'b1;
				end else if (!(cur_valid_q && cur_st_q == ST_RUNNING)) begin
					cur_q       <= '0;
					cur_valid_q <= 1'b0;
				end
			end else if (!pick_stall) begin
				pick_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (found_q) begin
				pick_word_q <= '{1'b1, to_idx(pick_q), 1'b0, 1'b0};
			end else if (cur_valid_q && cur_st_q == ST_RUNNING) begin
				pick_word_q <= '{1'b1, to_idx(cur_q), 1'b1, 1'b0};
			end else begin
				pick_word_q <= '{1'b0, '0, 1'b0, !live_q};
			end
		end
	end

	assign pick_valid = pick_valid_q;
	assign pick_word  = pick_word_q;

endmodule

### hw/rtl/round_robin_task_picker_core.sv
// Round-robin task picker, top level.
// Depends on rrtp_pkg, rrtp_ctrl and rrtp_datapath.
//
// Holds a table of NUM_ENTRIES task statuses and a current-task register.
// Words on the task channel either set one entry's status (kind write, no
// result) or ask for the next task (kind yield, one result word on the pick
// channel). A yield reads the status table through its single read port, one
// entry per cycle, circularly from just after the current task, and stops at
// the first runnable entry. If no entry is runnable the still-running current
// task is kept, otherwise the picker halts and flags whether any task is
// alive at all. After reset the table is swept to free, during which task
// words are stalled. A finished result sits in the output register; write
// words are still taken while it waits, and a further yield may scan but
// holds until it is drained.
module round_robin_task_picker_core #(
	parameter int NUM_ENTRIES = rrtp_pkg::NUM_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 task_valid,
	output logic                 task_stall,
	input  rrtp_pkg::task_word_t task_word,
	output logic                 pick_valid,
	input  logic                 pick_stall,
	output rrtp_pkg::pick_word_t pick_word
);
	import rrtp_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencing: clear sweep, idle, scan, result hand-off
	rrtp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (task_valid),
		.task_kind  (task_word.kind),
		.task_stall (task_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// status memory, scan pointer, current task and output register
	rrtp_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_word  (task_word),
		.cmd        (cmd),
		.sts        (sts),
		.pick_valid (pick_valid),
		.pick_stall (pick_stall),
		.pick_word  (pick_word)
	);

endmodule

### dv/tb_round_robin_task_picker_core.sv
// Self-checking testbench for round_robin_task_picker_core.
// Depends on rrtp_pkg and the picker RTL; a mirror of the status table
// predicts each pick word and a directed table plus random episodes drive it.
`timescale 1ns / 1ps

module tb_round_robin_task_picker_core;
	import rrtp_pkg::*;

	localparam int N_ENT       = NUM_ENTRIES_DEF;
	localparam int TOTAL_WORDS = 580;
	localparam int STALL_LIMIT = 20000;  // cycles with no word moving on either channel
	localparam int DRAIN_WAIT  = N_ENT + 8;  // longest yield scan plus margin

	// status codes the package leaves unnamed
	localparam logic [ST_W-1:0] ST_NOT_RUNNABLE = 3'd4;
	localparam logic [ST_W-1:0] ST_BAD_5        = 3'd5;
	localparam logic [ST_W-1:0] ST_BAD_6        = 3'd6;
	localparam logic [ST_W-1:0] ST_BAD_7        = 3'd7;

	// pick words that can be read straight off the rules
	localparam pick_word_t HALT_NONE_LIVE = '{1'b0, 10'd0, 1'b0, 1'b1};
	localparam pick_word_t HALT_LIVE      = '{1'b0, 10'd0, 1'b0, 1'b0};
	localparam pick_word_t NO_PICK        = '0;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] idx;
		logic [ST_W-1:0]  st;
		bit               typed;   // expectation typed in below, else predicted
		pick_word_t       pick;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	// Directed walk: empty table, wrap at the top index, current task still
	// runnable, kept running task, dying current task, unknown codes and a
	// halt with nothing live left.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, HALT_NONE_LIVE},
		'{KIND_WRITE, 10'd1023, ST_RUNNABLE,     1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, '{1'b1, 10'd1023, 1'b0, 1'b0}},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, '{1'b1, 10'd1023, 1'b0, 1'b0}},
		'{KIND_WRITE, 10'd1023, ST_RUNNING,      1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, '{1'b1, 10'd1023, 1'b1, 1'b0}},
		'{KIND_WRITE, 10'd0,    ST_RUNNABLE,     1'b0, NO_PICK},
		'{KIND_YIELD, 10'd1023, ST_BAD_7,        1'b1, '{1'b1, 10'd0, 1'b0, 1'b0}},
		'{KIND_WRITE, 10'd0,    ST_DYING,        1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, HALT_LIVE},
		'{KIND_WRITE, 10'd1023, ST_FREE,         1'b0, NO_PICK},
		'{KIND_WRITE, 10'd0,    ST_FREE,         1'b0, NO_PICK},
		'{KIND_WRITE, 10'd5,    ST_BAD_7,        1'b0, NO_PICK},
		'{KIND_WRITE, 10'd6,    ST_BAD_5,        1'b0, NO_PICK},
		'{KIND_WRITE, 10'd7,    ST_NOT_RUNNABLE, 1'b0, NO_PICK},
		'{KIND_WRITE, 10'd511,  ST_BAD_6,        1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, HALT_NONE_LIVE},
		'{KIND_WRITE, 10'd512,  ST_RUNNABLE,     1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, '{1'b1, 10'd512, 1'b0, 1'b0}},
		'{KIND_WRITE, 10'd512,  ST_RUNNING,      1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, '{1'b1, 10'd512, 1'b1, 1'b0}},
		'{KIND_WRITE, 10'd512,  ST_FREE,         1'b0, NO_PICK},
		'{KIND_YIELD, 10'd0,    ST_FREE,         1'b1, HALT_NONE_LIVE},
		'{KIND_WRITE, 10'd682,  ST_RUNNABLE,     1'b0, NO_PICK},
		'{KIND_YIELD, 10'd341,  ST_BAD_7,        1'b0, NO_PICK}
	};

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       task_valid = 1'b0;
	logic       task_stall;
	task_word_t task_word  = '0;
	logic       pick_valid;
	logic       pick_stall = 1'b0;
	pick_word_t pick_word;

	// mirror of the picker's state
	logic [ST_W-1:0]  mirror_status [N_ENT];
	logic [IDX_W-1:0] mirror_cur       = '0;
	bit               mirror_cur_valid = 1'b0;

	pick_word_t picks_due [$];

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int fail_count      = 0;
	int idle_cycles     = 0;
	int words_sent      = 0;
	int writes_sent     = 0;
	int yields_sent     = 0;
	int picks_seen      = 0;
	int kept_seen       = 0;
	int halts_seen      = 0;
	int empty_halts     = 0;

	round_robin_task_picker_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (task_valid),
		.task_stall (task_stall),
		.task_word  (task_word),
		.pick_valid (pick_valid),
		.pick_stall (pick_stall),
		.pick_word  (pick_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one accepted word to the mirror; returns 1 when a pick word is due.
	function automatic bit apply_task_word(input task_word_t w, output pick_word_t p);
		int unsigned k;
		int unsigned e;
		bit          found;
		bit          live;
		p     = '0;
		found = 1'b0;
		live  = 1'b0;
		if (w.kind == KIND_WRITE) begin
			if (w.entry_index < N_ENT)
				mirror_status[w.entry_index] = w.new_status;
			return 1'b0;
		end
		// circular scan: after the current task and ending on it, else from 0 up
		for (k = 0; k < N_ENT && !found; k++) begin
			e = mirror_cur_valid ? (mirror_cur + 1 + k) % N_ENT : k;
			if (mirror_status[e] == ST_RUNNABLE) begin
				found          = 1'b1;
				p.chosen_valid = 1'b1;
				p.chosen_index = e[IDX_W-1:0];
			end
		end
		if (found) begin
			mirror_cur       = p.chosen_index;
			mirror_cur_valid = 1'b1;
		end else if (mirror_cur_valid && mirror_status[mirror_cur] == ST_RUNNING) begin
			p.chosen_valid = 1'b1;
			p.chosen_index = mirror_cur;
			p.kept_current = 1'b1;
		end else begin
			mirror_cur       = '0;
			mirror_cur_valid = 1'b0;
			foreach (mirror_status[i])
				if (mirror_status[i] inside {ST_DYING, ST_RUNNABLE, ST_RUNNING})
					live = 1'b1;
			p.no_live_tasks = !live;
		end
		return 1'b1;
	endfunction

	// Status draw weighted towards runnable and running so picks and keeps occur.
	function automatic logic [ST_W-1:0] draw_status();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return ST_RUNNABLE;
		else if (r < 55)
			return ST_RUNNING;
		else if (r < 67)
			return ST_DYING;
		else if (r < 80)
			return ST_FREE;
		else if (r < 90)
			return ST_NOT_RUNNABLE;
		else
			return ST_W'(ST_BAD_5 + $urandom_range(2));
	endfunction

	function automatic void check_field(input string name, input int due, input int got);
		if (due != got) begin
			$error("%s: expected %0d, got %0d", name, due, got);
			fail_count++;
		end
	endfunction

	// Presents one word, holds it through stalls, then updates the mirror.
	task automatic send_word(input task_word_t w, input bit typed, input pick_word_t typed_pick);
		pick_word_t predicted;
		pick_word_t due;
		while ($urandom_range(99) < sender_idle_pct) begin
			task_valid <= 1'b0;
			@(posedge clk);
		end
		task_valid <= 1'b1;
		task_word  <= w;
		@(posedge clk);
		while (task_stall)
			@(posedge clk);
		words_sent++;
		if (apply_task_word(w, predicted)) begin
			due = typed ? typed_pick : predicted;
			picks_due.push_back(due);
			yields_sent++;
			if (!due.chosen_valid) begin
				halts_seen++;
				if (due.no_live_tasks)
					empty_halts++;
			end else begin
				picks_seen++;
				if (due.kept_current)
					kept_seen++;
			end
		end else begin
			writes_sent++;
		end
	endtask

	task automatic send_write(input int unsigned idx, input logic [ST_W-1:0] st);
		task_word_t w;
		w.kind        = KIND_WRITE;
		w.entry_index = idx[IDX_W-1:0];
		w.new_status  = st;
		send_word(w, 1'b0, NO_PICK);
	endtask

	task automatic send_yield();
		task_word_t w;
		w.kind        = KIND_YIELD;
		w.entry_index = IDX_W'($urandom_range(N_ENT - 1));
		w.new_status  = ST_W'($urandom_range(7));
		send_word(w, 1'b0, NO_PICK);
	endtask

	// Drops valid and waits until every due pick word has been taken.
	task automatic drain_picks();
		task_valid <= 1'b0;
		@(posedge clk);
		while (picks_due.size() != 0)
			@(posedge clk);
	endtask

	// receiver stalls at the rate of the current phase
	always @(posedge clk)
		pick_stall <= ($urandom_range(99) < recv_stall_pct);

	// pick word checker
	always @(posedge clk) begin : pick_check
		pick_word_t due;
		if (arst_n && pick_valid && !pick_stall) begin
			if (picks_due.size() == 0) begin
				$error("pick word with none due: chosen_valid %0d chosen_index %0d",
					pick_word.chosen_valid, pick_word.chosen_index);
				fail_count++;
			end else begin
				due = picks_due.pop_front();
				check_field("chosen_valid", int'(due.chosen_valid),
					int'(pick_word.chosen_valid));
				check_field("chosen_index", int'(due.chosen_index),
					int'(pick_word.chosen_index));
				check_field("kept_current", int'(due.kept_current),
					int'(pick_word.kept_current));
				check_field("no_live_tasks", int'(due.no_live_tasks),
					int'(pick_word.no_live_tasks));
			end
		end
	end

	// Watchdog: the slowest legal gap is a full table scan behind receiver
	// stalls, or the clearing sweep after reset; the limit is well above both.
	always @(posedge clk) begin
		if ((task_valid && !task_stall) || (pick_valid && !pick_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int          phase;
		int          last_phase;
		int unsigned base;
		int unsigned span;
		int          len;
		int          r;
		foreach (mirror_status[i])
			mirror_status[i] = ST_FREE;
		last_phase = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling; task words stall during the clearing sweep
		foreach (dir_rows[i])
			send_word(task_word_t'{dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].st},
				dir_rows[i].typed, dir_rows[i].pick);

		// Random episodes: writes clustered in a window (at times wrapping past
		// the top index), retargets of the current task, yields and some
		// full-range noise; half the episodes end by freeing every live
		// entry so that empty halts come up too.
		while (words_sent < TOTAL_WORDS) begin
			phase = (words_sent - DIR_ROWS) * 4 / (TOTAL_WORDS - DIR_ROWS);
			if (phase > 3)
				phase = 3;
			if (phase != last_phase) begin
				drain_picks();
				last_phase = phase;
				case (phase)
					1: begin
						sender_idle_pct = 54;
						recv_stall_pct  = 0;
					end
					2: begin
						sender_idle_pct = 0;
						recv_stall_pct  = 54;
					end
					default: begin
						sender_idle_pct = 10;
						recv_stall_pct  = 10;
					end
				endcase
			end

			base = $urandom_range(N_ENT - 1);
			span = $urandom_range(40, 3);
			len  = $urandom_range(30, 8);
			repeat (len) begin
				r = $urandom_range(99);
				if (r < 35)
					send_yield();
				else if (r < 55)
					send_write(mirror_cur_valid ? 32'(mirror_cur) : base, draw_status());
				else if (r < 90)
					send_write((base + $urandom_range(span - 1)) % N_ENT, draw_status());
				else
					send_write($urandom_range(N_ENT - 1), ST_W'($urandom_range(7)));
			end
			if ($urandom_range(1)) begin
				foreach (mirror_status[i])
					if (mirror_status[i] inside {ST_DYING, ST_RUNNABLE, ST_RUNNING})
						send_write(i, ST_FREE);
				send_yield();
			end
		end

		task_valid <= 1'b0;
		while (picks_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d task words: %0d status writes, %0d yields.",
			words_sent, writes_sent, yields_sent);
		$display("Yields gave %0d picks (%0d kept the running task), %0d halts (%0d empty).",
			picks_seen, kept_seen, halts_seen, empty_halts);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### round_robin_task_picker_core.f
hw/rtl/rrtp_pkg.sv
hw/rtl/rrtp_ctrl.sv
hw/rtl/rrtp_datapath.sv
hw/rtl/round_robin_task_picker_core.sv
dv/tb_round_robin_task_picker_core.sv
